/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL; clock and reset names are fixed.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante
`define SVEF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define SVEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/svef_pkg.sv */
`default_nettype none

package svef_pkg;

  // Default frame limits
  localparam int unsigned MaxWidthDef  = 512;
  localparam int unsigned MaxHeightDef = 512;

  // Field and register widths
  localparam int unsigned DimW     = 10;
  localparam int unsigned PixW     = 8;
  localparam int unsigned CfgAddrW = 2;

  // Frame size after reset
  localparam logic [DimW-1:0] DimReset = DimW'(512);

  // Result queue
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 2);

  typedef enum logic [CfgAddrW-1:0] {
    CfgFrameWidth  = 2'd0,
    CfgFrameHeight = 2'd1
  } cfg_reg_e;

  // Output position flags for one beat
  typedef struct packed {
    logic emit;
    logic has_left;
    logic has_right;
    logic has_top;
    logic has_bot;
    logic last;
  } pos_t;

  // One line store entry: pixel two rows up and one row up
  typedef struct packed {
    logic [PixW-1:0] older;
    logic [PixW-1:0] recent;
  } line_ent_t;

  typedef struct packed {
    logic [PixW-1:0] edge_value;
    logic            last_of_frame;
  } result_t;

  // Zero acts as one, anything above the limit acts as the limit
  function automatic logic [DimW-1:0] clamp_dim(logic [DimW-1:0] v, int unsigned maxv);
    logic [DimW-1:0] r;
    if (v == '0) begin
      r = DimW'(1);
    end else if (32'(v) > maxv) begin
      r = DimW'(maxv);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/svef_ifs.sv */
`default_nettype none

// Pixel input channel
interface svef_pix_if;
  import svef_pkg::*;
  logic            valid;
  logic            ready;
  logic            mode;
  logic [PixW-1:0] pixel;
  modport source (output valid, mode, pixel, input ready);
  modport sink   (input valid, mode, pixel, output ready);
endinterface

// Result output channel
interface svef_res_if;
  import svef_pkg::*;
  logic            valid;
  logic            ready;
  logic [PixW-1:0] edge_value;
  logic            last_of_frame;
  modport source (output valid, edge_value, last_of_frame, input ready);
  modport sink   (input valid, edge_value, last_of_frame, output ready);
endinterface

// Configuration write channel
interface svef_cfg_if;
  import svef_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgAddrW-1:0] addr;
  logic [DimW-1:0]     data;
  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/svef_ctrl.sv */
`default_nettype none

module svef_ctrl #(
  parameter int unsigned MaxWidth  = svef_pkg::MaxWidthDef,
  parameter int unsigned MaxHeight = svef_pkg::MaxHeightDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [svef_pkg::CfgAddrW-1:0] cfg_addr_i,
  input  logic [svef_pkg::DimW-1:0]     cfg_data_i,
  input  logic                          step_i,
  output logic [svef_pkg::DimW-1:0]     col_o,
  output svef_pkg::pos_t                pos_o
);
  import svef_pkg::*;

  logic [DimW-1:0] width_q, width_d;
  logic [DimW-1:0] height_q, height_d;
  logic [DimW-1:0] in_col_q, in_col_d;
  logic [1:0]      in_row_q, in_row_d;   // saturates at two
  logic [DimW-1:0] out_col_q, out_col_d;
  logic [DimW-1:0] out_row_q, out_row_d;
  logic [DimW-1:0] w_eff, h_eff;
  logic            restart;

  assign w_eff = clamp_dim(width_q, MaxWidth);
  assign h_eff = clamp_dim(height_q, MaxHeight);

  // Derive flags for the beat at the current position
  always_comb begin
    pos_o.emit      = in_row_q[1] || (in_row_q == 2'd1 && in_col_q != '0);
    pos_o.has_left  = out_col_q != '0;
    pos_o.has_right = out_col_q != (w_eff - DimW'(1));
    pos_o.has_top   = out_row_q != '0;
    pos_o.has_bot   = out_row_q != (h_eff - DimW'(1));
    pos_o.last      = !pos_o.has_bot && !pos_o.has_right;
  end

  assign col_o = in_col_q;

  // Advance positions, restart on config write or last result
  always_comb begin
    width_d   = width_q;
    height_d  = height_q;
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    restart   = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CfgFrameWidth: begin
          width_d = cfg_data_i;
          restart = 1'b1;
        end
        CfgFrameHeight: begin
          height_d = cfg_data_i;
          restart  = 1'b1;
        end
        default: ;
      endcase
    end else if (step_i) begin
      if (pos_o.emit && pos_o.last) begin
        restart = 1'b1;
      end else begin
        if (pos_o.emit) begin
          if (!pos_o.has_right) begin
            out_col_d = '0;
            out_row_d = out_row_q + DimW'(1);
          end else begin
            out_col_d = out_col_q + DimW'(1);
          end
        end
        if (in_col_q == (w_eff - DimW'(1))) begin
          in_col_d = '0;
          in_row_d = in_row_q[1] ? in_row_q : in_row_q + 2'd1;
        end else begin
          in_col_d = in_col_q + DimW'(1);
        end
      end
    end
    if (restart) begin
      in_col_d  = '0;
      in_row_d  = '0;
      out_col_d = '0;
      out_row_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= DimReset;
      height_q  <= DimReset;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else begin
      width_q   <= width_d;
      height_q  <= height_d;
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/svef_line_mem.sv */
`default_nettype none

module svef_line_mem #(
  parameter int unsigned Depth = svef_pkg::MaxWidthDef,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  svef_pkg::line_ent_t  wr_data_i,
  output svef_pkg::line_ent_t  rd_data_o
);
  import svef_pkg::*;

  line_ent_t mem_q [Depth];
  line_ent_t rd_data_q;

  // Write back the shifted column
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read, forward a write to the same column
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && wr_addr_i == rd_addr_i) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

`default_nettype wire

/* hw/rtl/svef_grad.sv */
`default_nettype none

module svef_grad #(
  parameter int unsigned AddrW = $clog2(svef_pkg::MaxWidthDef)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic                      mode_i,
  input  logic [svef_pkg::PixW-1:0] pixel_i,
  input  logic [AddrW-1:0]          addr_i,
  input  svef_pkg::pos_t            pos_i,
  input  svef_pkg::line_ent_t       rd_data_i,
  output logic                      wr_en_o,
  output logic [AddrW-1:0]          wr_addr_o,
  output svef_pkg::line_ent_t       wr_data_o,
  output logic                      valid_o,
  output logic                      push_o,
  output svef_pkg::result_t         result_o
);
  import svef_pkg::*;

  logic            s1_valid_q;
  pos_t            s1_pos_q;
  logic [PixW-1:0] s1_px_q;
  logic [AddrW-1:0] s1_addr_q;
  // bot_q: the two previous pixels; top_q: the two previous upper taps
  logic [PixW-1:0] bot_q [2];
  logic [PixW-1:0] top_q [2];
  logic [DimW-1:0] below, above, diff;

  // Capture the beat; drain beats carry a zero pixel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= step_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      s1_pos_q  <= pos_i;
      s1_px_q   <= mode_i ? '0 : pixel_i;
      s1_addr_q <= addr_i;
    end
  end

  // Shift the window once the column read is back
  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      bot_q[0] <= s1_px_q;
      bot_q[1] <= bot_q[0];
      top_q[0] <= rd_data_i.older;
      top_q[1] <= top_q[0];
    end
  end

  // Move the column down one row in the line store
  assign wr_en_o          = s1_valid_q;
  assign wr_addr_o        = s1_addr_q;
  assign wr_data_o.older  = rd_data_i.recent;
  assign wr_data_o.recent = s1_px_q;

  // Weighted rows with zero padding at the edges
  always_comb begin
    below = '0;
    above = '0;
    if (s1_pos_q.has_bot) begin
      below = {1'b0, bot_q[0], 1'b0};
      if (s1_pos_q.has_left) below = below + DimW'(bot_q[1]);
      if (s1_pos_q.has_right) below = below + DimW'(s1_px_q);
    end
    if (s1_pos_q.has_top) begin
      above = {1'b0, top_q[0], 1'b0};
      if (s1_pos_q.has_left) above = above + DimW'(top_q[1]);
      if (s1_pos_q.has_right) above = above + DimW'(rd_data_i.older);
    end
  end

  // Clamp the difference to a pixel
  always_comb begin
    diff = below - above;
    if (below <= above) begin
      result_o.edge_value = '0;
    end else if (diff[DimW-1:PixW] != '0) begin
      result_o.edge_value = '1;
    end else begin
      result_o.edge_value = diff[PixW-1:0];
    end
    result_o.last_of_frame = s1_pos_q.last;
  end

  assign valid_o = s1_valid_q;
  assign push_o  = s1_valid_q && s1_pos_q.emit;

endmodule

`default_nettype wire

/* hw/rtl/svef_out_fifo.sv */
`default_nettype none

module svef_out_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  svef_pkg::result_t             data_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output svef_pkg::result_t             data_o,
  output logic [svef_pkg::FifoCntW-1:0] cnt_o
);
  import svef_pkg::*;

  result_t             buf_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  // Store a result beat
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= data_i;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) cnt_d = cnt_q + FifoCntW'(1);
    if (pop_i && !push_i) cnt_d = cnt_q - FifoCntW'(1);
  end

  // Advance pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FifoPtrW'(1);
      if (pop_i) rd_ptr_q <= rd_ptr_q + FifoPtrW'(1);
      cnt_q <= cnt_d;
    end
  end

  assign valid_o = cnt_q != '0;
  assign data_o  = buf_q[rd_ptr_q];
  assign cnt_o   = cnt_q;

endmodule

`default_nettype wire

/* hw/rtl/sobel_vertical_edge_filter.sv */
// Channel  Port   Dir  Payload
// pixel    pix_i  in   mode, pixel
// result   res_o  out  edge_value, last_of_frame
// config   cfg_i  in   addr (0 width, 1 height), data
//
// One beat per cycle on pix_i; its result passes the window stage and queue to res_o.
// Each beat reads one column of the line store and writes it back in the next cycle,
// on separate read and write ports, so the column access allows one beat per clock.
// pix_i stalls only when the four-entry result queue has no room; res_o is fed from it.
// The line store needs no clearing after reset: its stale rows sit at padded edges only.
`default_nettype none
`include "assert_macros.svh"

module sobel_vertical_edge_filter #(
  parameter int unsigned MAX_WIDTH  = svef_pkg::MaxWidthDef,
  parameter int unsigned MAX_HEIGHT = svef_pkg::MaxHeightDef
) (
  input logic      clk_i,
  input logic      rst_ni,
  svef_pix_if.sink   pix_i,
  svef_res_if.source res_o,
  svef_cfg_if.sink   cfg_i
);
  import svef_pkg::*;

  localparam int unsigned AddrW = $clog2(MAX_WIDTH);

  logic                pix_accept;
  logic                cfg_accept;
  logic [DimW-1:0]     col;
  pos_t                pos;
  line_ent_t           rd_data;
  line_ent_t           wr_data;
  logic                wr_en;
  logic [AddrW-1:0]    wr_addr;
  logic                s1_valid;
  logic                fifo_push;
  result_t             grad_res;
  result_t             fifo_res;
  logic [FifoCntW-1:0] fifo_cnt;

  // Take a beat only with room reserved for its result
  assign pix_i.ready = (fifo_cnt + FifoCntW'(s1_valid)) < FifoCntW'(FifoDepth);
  assign pix_accept  = pix_i.valid && pix_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_accept  = cfg_i.valid && cfg_i.ready;

  svef_ctrl #(
    .MaxWidth  (MAX_WIDTH),
    .MaxHeight (MAX_HEIGHT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_accept),
    .cfg_addr_i (cfg_i.addr),
    .cfg_data_i (cfg_i.data),
    .step_i     (pix_accept),
    .col_o      (col),
    .pos_o      (pos)
  );

  svef_line_mem #(
    .Depth (MAX_WIDTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rd_en_i   (pix_accept),
    .rd_addr_i (AddrW'(col)),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_data_o (rd_data)
  );

  svef_grad #(
    .AddrW (AddrW)
  ) u_grad (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (pix_accept),
    .mode_i    (pix_i.mode),
    .pixel_i   (pix_i.pixel),
    .addr_i    (AddrW'(col)),
    .pos_i     (pos),
    .rd_data_i (rd_data),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .valid_o   (s1_valid),
    .push_o    (fifo_push),
    .result_o  (grad_res)
  );

  svef_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (grad_res),
    .pop_i   (res_o.valid && res_o.ready),
    .valid_o (res_o.valid),
    .data_o  (fifo_res),
    .cnt_o   (fifo_cnt)
  );

  assign res_o.edge_value    = fifo_res.edge_value;
  assign res_o.last_of_frame = fifo_res.last_of_frame;

  // Every accepted beat reaches the window stage next cycle
  `SVEF_ASSERT_NEXT(a_beat_to_stage, pix_accept, s1_valid, "beat lost before window stage")
  // Reservation keeps the queue from overflowing
  `SVEF_ASSERT_NOW(a_no_overflow, fifo_push, fifo_cnt < FifoCntW'(FifoDepth),
                   "result queue overflow")
  // A result appears only after the window stage pushed one
  `SVEF_ASSERT_NOW(a_result_source, $rose(res_o.valid), $past(fifo_push),
                   "result without a push")

endmodule

`default_nettype wire
